>>> sv/bab_pkg.sv
`timescale 1ns / 1ps
// bab_pkg: shared constants, command and status codes, and word types
// for the block allocation bitmap unit. No dependencies.
package bab_pkg;

  // map geometry
  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_ROWS   = MAX_BLOCKS / WORD_W;
  localparam int ROW_AW     = $clog2(NUM_ROWS);
  localparam int ROW_W      = ROW_AW + 1;

  // command codes
  localparam logic [1:0] CMD_MARK = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_TEST = 2'd2;
  localparam logic [1:0] CMD_FIND = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // input word
  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] block_index;
  } bab_in_t;

  // result word
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] free_count;
    logic [IDX_W-1:0] lowest_free;
    logic             lowest_free_valid;
  } bab_out_t;

  // request to the row scanner
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W:0]    limit;
  } scan_req_t;

  // answer of the row scanner
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

>>> sv/bab_ram.sv
`timescale 1ns / 1ps
// bab_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module bab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bab_scan.sv
`timescale 1ns / 1ps
// bab_scan: finds the lowest clear bit of one map row between a start bit
// and a bit limit. Depends on bab_pkg.
module bab_scan (
  input  bab_pkg::scan_req_t req,
  output bab_pkg::scan_res_t res
);
  import bab_pkg::*;

  logic [WORD_W-1:0] cand;
  logic [BIT_W-1:0]  pos;

  // free bits inside the window
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      cand[i] = !req.word[i] &&
                ((BIT_W+1)'(i) >= {1'b0, req.lo_bit}) &&
                ((BIT_W+1)'(i) < req.limit);
    end
  end

  // priority encode, lowest bit wins
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign res.found = |cand;
  assign res.pos   = pos;

endmodule

>>> sv/block_allocation_bitmap_unit.sv
`timescale 1ns / 1ps
// block_allocation_bitmap_unit: top level of the free-space bitmap allocator.
// Depends on bab_pkg, bab_ram and bab_scan.
//
// Usage:
//  - in channel (in_valid/in_stall/in_data) carries one command word: mark
//    used, free, test used, or find the first free block from an index.
//  - out channel (out_valid/out_stall/out_data) returns one result word per
//    command: status, found index, free count and the tracked lowest free.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes block_count; it clears
//    the map at once and may only be used while no command is in flight.
// Mark, free and test go through the execute and done states to the result
// register; a bad index goes straight to done. Find, and a mark of the tracked
// lowest free block, scan the map one 32-bit row per cycle (request, then scan
// states) through the shared row scanner and RAM read port before done.
// One command is worked on at a time; in_stall is high until its result is
// in the output register, so no new command is taken before then.
// Reset clears the map (per-row valid flops, no sweep), sets block_count and
// the free count to 1024 and the lowest free to block 0.
// While out_stall is high a finished result waits in the output register and
// the next result holds in the sequencer until it is taken.
module block_allocation_bitmap_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bab_pkg::bab_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bab_pkg::bab_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [bab_pkg::CNT_W-1:0] cfg_data
);
  import bab_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SREQ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  block_count_r, block_count_nxt;
  logic [CNT_W-1:0]  free_total_r, free_total_nxt;
  logic [IDX_W-1:0]  first_free_r, first_free_nxt;
  logic              first_free_ok_r, first_free_ok_nxt;
  logic [NUM_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [ROW_W-1:0]  srch_row_r, srch_row_nxt;
  logic [BIT_W-1:0]  from_bit_r, from_bit_nxt;
  logic              first_row_r, first_row_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_found_r, res_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  bab_out_t          out_data_r, out_data_nxt;

  logic              ram_wr_en, ram_rd_en;
  logic [ROW_AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [WORD_W-1:0] ram_wr_data, ram_rd_data;
  logic [ROW_AW-1:0] rd_row_r, rd_row_nxt;

  logic [WORD_W-1:0] cur_word;
  logic              cur_bit;
  logic [CNT_W-1:0]  srch_base, next_base, rem_bits, cfg_clamped, mark_from;
  logic              in_acc;
  scan_req_t         scan_req;
  scan_res_t         scan_res;

  // map storage, one row of blocks per word
  bab_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ROWS)) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // shared row scanner
  bab_scan u_scan (
    .req (scan_req),
    .res (scan_res)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // rows never written since the last clear read as all free
  assign cur_word  = row_valid_r[rd_row_r] ? ram_rd_data : '0;
  assign cur_bit   = cur_word[idx_r[BIT_W-1:0]];
  assign mark_from = CNT_W'(idx_r) + CNT_W'(1);

  // search window bounds for the current row
  assign srch_base = {srch_row_r, {BIT_W{1'b0}}};
  assign next_base = srch_base + CNT_W'(WORD_W);
  assign rem_bits  = block_count_r - srch_base;

  assign scan_req.word   = cur_word;
  assign scan_req.lo_bit = first_row_r ? from_bit_r : '0;
  assign scan_req.limit  = (rem_bits >= CNT_W'(WORD_W)) ? (BIT_W+1)'(WORD_W)
                                                        : rem_bits[BIT_W:0];

  // register write clamp
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(MAX_BLOCKS)) begin
      cfg_clamped = CNT_W'(MAX_BLOCKS);
    end
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    idx_nxt           = idx_r;
    block_count_nxt   = block_count_r;
    free_total_nxt    = free_total_r;
    first_free_nxt    = first_free_r;
    first_free_ok_nxt = first_free_ok_r;
    row_valid_nxt     = row_valid_r;
    srch_row_nxt      = srch_row_r;
    from_bit_nxt      = from_bit_r;
    first_row_nxt     = first_row_r;
    res_status_nxt    = res_status_r;
    res_found_nxt     = res_found_r;
    out_valid_nxt     = out_valid_r;
    out_data_nxt      = out_data_r;
    rd_row_nxt        = rd_row_r;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = idx_r[IDX_W-1:BIT_W];
    ram_wr_data       = cur_word;
    ram_rd_en         = 1'b0;
    ram_rd_addr       = rd_row_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_data.command;
          idx_nxt        = in_data.block_index;
          res_found_nxt  = '0;
          res_status_nxt = ST_DONE;
          if (CNT_W'(in_data.block_index) >= block_count_r) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = in_data.block_index[IDX_W-1:BIT_W];
            rd_row_nxt  = in_data.block_index[IDX_W-1:BIT_W];
            state_nxt   = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_MARK: begin
            if (cur_bit) begin
              res_status_nxt = ST_REFUSED;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_data = cur_word | (WORD_W'(1) << idx_r[BIT_W-1:0]);
              row_valid_nxt[idx_r[IDX_W-1:BIT_W]] = 1'b1;
              if (free_total_r != '0) begin
                free_total_nxt = free_total_r - CNT_W'(1);
              end
              if (first_free_ok_r && idx_r == first_free_r) begin
                srch_row_nxt  = mark_from[CNT_W-1:BIT_W];
                from_bit_nxt  = mark_from[BIT_W-1:0];
                first_row_nxt = 1'b1;
                state_nxt     = S_SREQ;
              end
            end
          end
          CMD_FREE: begin
            if (!cur_bit) begin
              res_status_nxt = ST_REFUSED;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_data = cur_word & ~(WORD_W'(1) << idx_r[BIT_W-1:0]);
              row_valid_nxt[idx_r[IDX_W-1:BIT_W]] = 1'b1;
              free_total_nxt = free_total_r + CNT_W'(1);
              if (!first_free_ok_r || idx_r < first_free_r) begin
                first_free_nxt    = idx_r;
                first_free_ok_nxt = 1'b1;
              end
            end
          end
          CMD_TEST: begin
            res_status_nxt = cur_bit ? ST_DONE : ST_REFUSED;
          end
          default: begin
            srch_row_nxt  = {1'b0, idx_r[IDX_W-1:BIT_W]};
            from_bit_nxt  = idx_r[BIT_W-1:0];
            first_row_nxt = 1'b1;
            state_nxt     = S_SREQ;
          end
        endcase
      end

      S_SREQ: begin
        if (srch_base >= block_count_r) begin
          // nothing left to search
          if (cmd_r == CMD_MARK) begin
            first_free_nxt    = '0;
            first_free_ok_nxt = 1'b0;
          end else begin
            res_status_nxt = ST_REFUSED;
          end
          state_nxt = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = srch_row_r[ROW_AW-1:0];
          rd_row_nxt  = srch_row_r[ROW_AW-1:0];
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_res.found) begin
          if (cmd_r == CMD_MARK) begin
            first_free_nxt = {srch_row_r[ROW_AW-1:0], scan_res.pos};
          end else begin
            res_found_nxt = {srch_row_r[ROW_AW-1:0], scan_res.pos};
          end
          state_nxt = S_DONE;
        end else if (next_base >= block_count_r) begin
          if (cmd_r == CMD_MARK) begin
            first_free_nxt    = '0;
            first_free_ok_nxt = 1'b0;
          end else begin
            res_status_nxt = ST_REFUSED;
          end
          state_nxt = S_DONE;
        end else begin
          // fetch the next row while this one is checked
          srch_row_nxt  = srch_row_r + ROW_W'(1);
          first_row_nxt = 1'b0;
          ram_rd_en     = 1'b1;
          ram_rd_addr   = srch_row_nxt[ROW_AW-1:0];
          rd_row_nxt    = srch_row_nxt[ROW_AW-1:0];
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.status            = res_status_r;
          out_data_nxt.found_index       = res_found_r;
          out_data_nxt.free_count        = free_total_r;
          out_data_nxt.lowest_free       = first_free_ok_r ? first_free_r : '0;
          out_data_nxt.lowest_free_valid = first_free_ok_r;
          state_nxt                      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register write clears the map
    if (cfg_valid && cfg_ready) begin
      block_count_nxt   = cfg_clamped;
      free_total_nxt    = cfg_clamped;
      first_free_nxt    = '0;
      first_free_ok_nxt = 1'b1;
      row_valid_nxt     = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      block_count_r   <= CNT_W'(MAX_BLOCKS);
      free_total_r    <= CNT_W'(MAX_BLOCKS);
      first_free_r    <= '0;
      first_free_ok_r <= 1'b1;
      row_valid_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      block_count_r   <= block_count_nxt;
      free_total_r    <= free_total_nxt;
      first_free_r    <= first_free_nxt;
      first_free_ok_r <= first_free_ok_nxt;
      row_valid_r     <= row_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    srch_row_r   <= srch_row_nxt;
    from_bit_r   <= from_bit_nxt;
    first_row_r  <= first_row_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
    rd_row_r     <= rd_row_nxt;
  end

  // free count never exceeds the block count
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= block_count_r)
    else $error("free count above block count");

  // tracked lowest free block lies inside the store
  a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_free_ok_r |-> (CNT_W'(first_free_r) < block_count_r))
    else $error("lowest free block out of range");

  // an accepted word leaves the idle state
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accept");

  // a row is only scanned while inside the store
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (srch_base < block_count_r))
    else $error("scan past block count");

  // a result is loaded only from the done state
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside done state");

endmodule
